### sv/rsgri_pkg.sv
// Package for the RC stick gimbal rate integrator.
// Holds register indexes, register reset values and zoom request codes.
// No dependencies.
package rsgri_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STICK_CENTER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STICK_DEADBAND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_LIMIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_UPPER    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_LOWER    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_IN_LEVEL  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_OUT_LEVEL = 3'd7;

  localparam logic [15:0]        RST_STICK_CENTER   = 16'd1515;
  localparam logic [14:0]        RST_STICK_DEADBAND = 15'd206;
  localparam logic [7:0]         RST_ANGLE_STEP     = 8'd3;
  localparam logic [10:0]        RST_YAW_LIMIT      = 11'd1350;
  localparam logic signed [11:0] RST_PITCH_UPPER    = 12'sd250;
  localparam logic signed [11:0] RST_PITCH_LOWER    = -12'sd900;
  localparam logic [15:0]        RST_ZOOM_IN_LEVEL  = 16'd1102;
  localparam logic [15:0]        RST_ZOOM_OUT_LEVEL = 16'd1927;

  typedef logic [1:0] zoom_t;
  localparam zoom_t ZOOM_NONE = 2'd0;
  localparam zoom_t ZOOM_IN   = 2'd1;
  localparam zoom_t ZOOM_OUT  = 2'd2;

endpackage

### sv/rc_stick_gimbal_rate_integrator_core.sv
// Datapath: an input transaction passes through the input register, then the result
// register holding the stepped, clamped angles.
// Throughput: one transaction per cycle while m_tready keeps the output moving; the
// step, clamp and switch compares sit between the input and result registers.
// Reset: synchronous, active high; angles and switch history clear, registers take
// their default values, both channels go empty.
module rc_stick_gimbal_rate_integrator_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [rsgri_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsgri_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // yaw_stick, pitch_stick, recenter_button, snapshot_button, zoom_rocker
  input  logic [79:0]                         s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // yaw_angle, pitch_angle, snapshot_pulse, zoom_request, zero fill
  output logic [31:0]                         m_tdata
);

  logic [15:0]        stick_center;
  logic [14:0]        stick_deadband;
  logic [7:0]         angle_step;
  logic [10:0]        yaw_limit;
  logic signed [11:0] pitch_upper;
  logic signed [11:0] pitch_lower;
  logic [15:0]        zoom_in_level;
  logic [15:0]        zoom_out_level;

  logic        in_valid;
  logic [15:0] in_yaw;
  logic [15:0] in_pitch;
  logic [15:0] in_recenter;
  logic [15:0] in_snapshot;
  logic [15:0] in_zoom;

  logic signed [11:0] yaw_pos;
  logic signed [11:0] pitch_pos;
  logic [15:0]        recenter_prev;
  logic [15:0]        snapshot_prev;

  logic signed [11:0] out_yaw;
  logic signed [11:0] out_pitch;
  logic               out_pulse;
  rsgri_pkg::zoom_t   out_zoom;

  logic               advance;
  logic               fire;
  logic signed [17:0] db;
  logic signed [17:0] yaw_off;
  logic signed [17:0] pitch_off;
  logic signed [13:0] step;
  logic signed [13:0] yaw_delta;
  logic signed [13:0] pitch_delta;
  logic signed [13:0] yaw_sum;
  logic signed [13:0] pitch_sum;
  logic signed [13:0] yaw_hi;
  logic signed [13:0] yaw_lo;
  logic signed [13:0] pitch_hi;
  logic signed [13:0] pitch_lo;
  logic signed [13:0] yaw_top;
  logic signed [13:0] pitch_top;
  logic signed [13:0] yaw_clamp;
  logic signed [13:0] pitch_clamp;
  logic               rec_event;
  logic               snap_event;
  logic signed [11:0] yaw_next;
  logic signed [11:0] pitch_next;
  rsgri_pkg::zoom_t   zoom_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_center   <= rsgri_pkg::RST_STICK_CENTER;
      stick_deadband <= rsgri_pkg::RST_STICK_DEADBAND;
      angle_step     <= rsgri_pkg::RST_ANGLE_STEP;
      yaw_limit      <= rsgri_pkg::RST_YAW_LIMIT;
      pitch_upper    <= rsgri_pkg::RST_PITCH_UPPER;
      pitch_lower    <= rsgri_pkg::RST_PITCH_LOWER;
      zoom_in_level  <= rsgri_pkg::RST_ZOOM_IN_LEVEL;
      zoom_out_level <= rsgri_pkg::RST_ZOOM_OUT_LEVEL;
    end else if (cfg_wen) begin
      case (cfg_index)
        rsgri_pkg::REG_STICK_CENTER:   stick_center   <= cfg_data;
        rsgri_pkg::REG_STICK_DEADBAND: stick_deadband <= cfg_data[14:0];
        rsgri_pkg::REG_ANGLE_STEP:     angle_step     <= cfg_data[7:0];
        rsgri_pkg::REG_YAW_LIMIT:      yaw_limit      <= cfg_data[10:0];
        rsgri_pkg::REG_PITCH_UPPER:    pitch_upper    <= $signed(cfg_data[11:0]);
        rsgri_pkg::REG_PITCH_LOWER:    pitch_lower    <= $signed(cfg_data[11:0]);
        rsgri_pkg::REG_ZOOM_IN_LEVEL:  zoom_in_level  <= cfg_data;
        rsgri_pkg::REG_ZOOM_OUT_LEVEL: zoom_out_level <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign fire     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_yaw      <= s_tdata[15:0];
      in_pitch    <= s_tdata[31:16];
      in_recenter <= s_tdata[47:32];
      in_snapshot <= s_tdata[63:48];
      in_zoom     <= s_tdata[79:64];
    end
  end

  always_comb begin
    db        = $signed({3'b000, stick_deadband});
    yaw_off   = $signed({2'b00, in_yaw}) - $signed({2'b00, stick_center});
    pitch_off = $signed({2'b00, in_pitch}) - $signed({2'b00, stick_center});
    step      = $signed({6'b000000, angle_step});

    if (yaw_off > db) begin
      yaw_delta = -step;
    end else if (yaw_off < -db) begin
      yaw_delta = step;
    end else begin
      yaw_delta = '0;
    end
    if (pitch_off > db) begin
      pitch_delta = -step;
    end else if (pitch_off < -db) begin
      pitch_delta = step;
    end else begin
      pitch_delta = '0;
    end

    yaw_sum   = {{2{yaw_pos[11]}}, yaw_pos} + yaw_delta;
    pitch_sum = {{2{pitch_pos[11]}}, pitch_pos} + pitch_delta;

    yaw_hi   = $signed({3'b000, yaw_limit});
    yaw_lo   = -yaw_hi;
    pitch_hi = {{2{pitch_upper[11]}}, pitch_upper};
    pitch_lo = {{2{pitch_lower[11]}}, pitch_lower};

    yaw_top     = (yaw_sum > yaw_hi) ? yaw_hi : yaw_sum;
    yaw_clamp   = (yaw_top < yaw_lo) ? yaw_lo : yaw_top;
    pitch_top   = (pitch_sum > pitch_hi) ? pitch_hi : pitch_sum;
    pitch_clamp = (pitch_top < pitch_lo) ? pitch_lo : pitch_top;

    rec_event  = (recenter_prev != '0) && (in_recenter != recenter_prev);
    snap_event = (snapshot_prev != '0) && (in_snapshot != snapshot_prev);

    yaw_next   = rec_event ? '0 : yaw_clamp[11:0];
    pitch_next = rec_event ? '0 : pitch_clamp[11:0];

    if (in_zoom <= zoom_in_level) begin
      zoom_next = rsgri_pkg::ZOOM_IN;
    end else if (in_zoom >= zoom_out_level) begin
      zoom_next = rsgri_pkg::ZOOM_OUT;
    end else begin
      zoom_next = rsgri_pkg::ZOOM_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_pos       <= '0;
      pitch_pos     <= '0;
      recenter_prev <= '0;
      snapshot_prev <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (advance) begin
        m_tvalid <= in_valid;
      end
      if (fire) begin
        yaw_pos       <= yaw_next;
        pitch_pos     <= pitch_next;
        recenter_prev <= in_recenter;
        snapshot_prev <= in_snapshot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_yaw   <= yaw_next;
      out_pitch <= pitch_next;
      out_pulse <= snap_event;
      out_zoom  <= zoom_next;
    end
  end

  assign m_tdata = {5'b00000, out_zoom, out_pulse, out_pitch, out_yaw};

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid && !in_valid)
    else $error("channels not empty after reset");

  a_stall_block: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while pipeline stalled");

  a_recenter_zero: assert property (@(posedge clk) disable iff (rst)
    (fire && rec_event) |=> (yaw_pos == '0) && (pitch_pos == '0))
    else $error("recenter did not zero angles");

  a_yaw_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed({{2{out_yaw[11]}}, out_yaw}) <= $signed({3'b000, yaw_limit}))
      && ($signed({{2{out_yaw[11]}}, out_yaw}) >= -$signed({3'b000, yaw_limit})))
    else $error("yaw outside limit");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(yaw_pos) && $stable(pitch_pos))
    else $error("angle state moved without a transaction");

endmodule
